// ----- rtl/cv9_pkg.sv -----
// ----------------------------------------------------------------------------
// cv9_pkg: shared types and constants of the 3x3 convolution filter
// Pixel, window and mask types, configuration register indexes, and the
// constants of the divide-by-nine and clamp step.
// ----------------------------------------------------------------------------
package cv9_pkg;

  typedef logic [7:0] pixel_t;

  // Window indexed [row][col]; row 0 is the oldest line, col 0 the oldest column.
  typedef logic [2:0][2:0][7:0] window_t;

  typedef struct packed {
    logic [23:0] top;
    logic [23:0] mid;
    logic [23:0] bot;
  } mask_t;

  typedef struct packed {
    logic [9:0] row;
    logic [9:0] col;
    logic       last;
  } res_meta_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int SIZE_IN_W  = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_MASK_TOP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_MID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_BOT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS     = 3'd4;

  localparam logic [23:0] MASK_RST = 24'h010101;
  localparam int ROWS_RST = 480;
  localparam int COLS_RST = 640;
  localparam int SIZE_MIN = 3;

  localparam int PROD_W = 17;
  localparam int SUM_W  = 20;

  // Sums at or above this value give 255 after the divide.
  localparam int DIV_CLAMP = 2304;
  // Below the clamp, s / 9 == (s * 7282) >> 16 for every 12-bit s.
  localparam int DIV_IN_W  = 12;
  localparam int RECIP_W   = 13;
  localparam int DIV_RECIP = 7282;
  localparam int DIV_SHIFT = 16;

  function automatic logic signed [7:0] mask_coef(logic [23:0] rowmask, logic [1:0] k);
    return $signed(rowmask[8*k +: 8]);
  endfunction

endpackage

// ----- rtl/cv9_if.sv -----
// ----------------------------------------------------------------------------
// cv9_in_if / cv9_out_if: pixel and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface cv9_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface cv9_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_pixel;
  logic [9:0] out_row;
  logic [9:0] out_col;
  logic       frame_last;

  modport source (output valid, output out_pixel, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink   (input valid, input out_pixel, input out_row, input out_col,
                  input frame_last, output ready);
endinterface

// ----- rtl/cv9_cfg.sv -----
// ----------------------------------------------------------------------------
// cv9_cfg: configuration registers
// Holds the three mask rows and the frame size, saturated on write.
// ----------------------------------------------------------------------------
module cv9_cfg
  import cv9_pkg::*;
#(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int CW = $clog2(MAX_COLS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output mask_t                 mask,
  output logic [RW:0]           rows,
  output logic [CW:0]           cols
);

  localparam int ROWS_RST_SAT = (ROWS_RST > MAX_ROWS) ? MAX_ROWS : ROWS_RST;
  localparam int COLS_RST_SAT = (COLS_RST > MAX_COLS) ? MAX_COLS : COLS_RST;

  mask_t       mask_r;
  logic [RW:0] rows_r;
  logic [CW:0] cols_r;

  function automatic logic [31:0] sat_size(logic [SIZE_IN_W-1:0] v, int maxv);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 < 32'(SIZE_MIN)) return 32'(SIZE_MIN);
    if (v32 > 32'(maxv)) return 32'(maxv);
    return v32;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r.top <= MASK_RST;
      mask_r.mid <= MASK_RST;
      mask_r.bot <= MASK_RST;
      rows_r     <= (RW+1)'(ROWS_RST_SAT);
      cols_r     <= (CW+1)'(COLS_RST_SAT);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MASK_TOP: mask_r.top <= cfg_wdata;
        CFG_MASK_MID: mask_r.mid <= cfg_wdata;
        CFG_MASK_BOT: mask_r.bot <= cfg_wdata;
        CFG_ROWS:     rows_r <= (RW+1)'(sat_size(cfg_wdata[SIZE_IN_W-1:0], MAX_ROWS));
        CFG_COLS:     cols_r <= (CW+1)'(sat_size(cfg_wdata[SIZE_IN_W-1:0], MAX_COLS));
        default: ;
      endcase
    end
  end

  assign mask = mask_r;
  assign rows = rows_r;
  assign cols = cols_r;

endmodule

// ----- rtl/cv9_window.sv -----
// ----------------------------------------------------------------------------
// cv9_window: raster position, line stores and 3x3 window
// Tracks the pixel position, reads both line stores at the pixel's column,
// writes them back one stage later and shifts the window.
// ----------------------------------------------------------------------------
module cv9_window
  import cv9_pkg::*;
#(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int CW = $clog2(MAX_COLS)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  pixel_t      in_pixel,
  input  logic        in_frame_start,
  input  logic [RW:0] rows,
  input  logic [CW:0] cols,
  output logic        win_valid,
  input  logic        win_ready,
  output window_t     window,
  output res_meta_t   meta
);

  localparam int RXW = (RW + 1 > 10) ? RW + 1 : 10;
  localparam int CXW = (CW + 1 > 10) ? CW + 1 : 10;

  pixel_t older_ram [MAX_COLS];
  pixel_t newer_ram [MAX_COLS];

  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;

  logic          s1_valid_r;
  pixel_t        s1_pix_r;
  logic [CW-1:0] s1_col_r;
  logic          s1_prod_r;
  res_meta_t     s1_meta_r;
  pixel_t        older_q_r, newer_q_r;
  logic          fwd_r;
  pixel_t        fwd_top_r, fwd_mid_r;

  logic          win_valid_r;
  window_t       win_r;
  res_meta_t     meta_r;

  logic          accept, s1_adv;
  logic [RW:0]   r0, r1, r, rn;
  logic [CW:0]   c0, c1, cn;
  logic [CW-1:0] c_addr;
  logic          prod;
  logic [RXW-1:0] rm1;
  logic [CXW-1:0] cm1;
  res_meta_t     meta_nxt;
  pixel_t        s1_top, s1_mid;

  assign s1_adv   = s1_valid_r && (!win_valid_r || win_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;

  // Position of the incoming pixel, then the position after it.
  always_comb begin
    r0 = in_frame_start ? '0 : {1'b0, row_r};
    c0 = in_frame_start ? '0 : {1'b0, col_r};
    if (c0 >= cols) begin
      c1 = '0;
      r1 = r0 + 1'b1;
    end else begin
      c1 = c0;
      r1 = r0;
    end
    r  = (r1 >= rows) ? '0 : r1;
    c_addr = c1[CW-1:0];
    cn = c1 + 1'b1;
    rn = r + 1'b1;
    if (cn >= cols) begin
      col_nxt = '0;
      row_nxt = (rn >= rows) ? '0 : rn[RW-1:0];
    end else begin
      col_nxt = cn[CW-1:0];
      row_nxt = r[RW-1:0];
    end
    prod = (r >= (RW+1)'(2)) && (c1 >= (CW+1)'(2));
    rm1  = RXW'(r) - 1'b1;
    cm1  = CXW'(c1) - 1'b1;
    meta_nxt.row  = rm1[9:0];
    meta_nxt.col  = cm1[9:0];
    meta_nxt.last = (r == rows - 1'b1) && (c1 == cols - 1'b1);
  end

  // The item ahead writes the same column in the cycle this one reads it
  // only after a frame start restarts the column count; forward its data.
  assign s1_top = fwd_r ? fwd_top_r : older_q_r;
  assign s1_mid = fwd_r ? fwd_mid_r : newer_q_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      older_q_r <= older_ram[c_addr];
      newer_q_r <= newer_ram[c_addr];
    end
    if (s1_adv) begin
      older_ram[s1_col_r] <= s1_mid;
      newer_ram[s1_col_r] <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      s1_valid_r  <= 1'b0;
      win_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        win_valid_r <= s1_prod_r;
      end else if (win_ready) begin
        win_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= in_pixel;
      s1_col_r  <= c_addr;
      s1_prod_r <= prod;
      s1_meta_r <= meta_nxt;
      fwd_r     <= s1_valid_r && (s1_col_r == c_addr);
      fwd_top_r <= s1_mid;
      fwd_mid_r <= s1_pix_r;
    end
    if (s1_adv) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= s1_top;
      win_r[1][2] <= s1_mid;
      win_r[2][2] <= s1_pix_r;
      meta_r      <= s1_meta_r;
    end
  end

  assign win_valid = win_valid_r;
  assign window    = win_r;
  assign meta      = meta_r;

endmodule

// ----- rtl/cv9_mac.sv -----
// ----------------------------------------------------------------------------
// cv9_mac: products, sum, divide by nine and clamp
// Three pipeline stages: nine products, their sum, then quotient and clamp
// into the output register.
// ----------------------------------------------------------------------------
module cv9_mac
  import cv9_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  mask_t      mask,
  input  logic       win_valid,
  output logic       win_ready,
  input  window_t    window,
  input  res_meta_t  meta,
  output logic       out_valid,
  input  logic       out_ready,
  output pixel_t     out_pixel,
  output logic [9:0] out_row,
  output logic [9:0] out_col,
  output logic       frame_last
);

  localparam int QW = DIV_IN_W + RECIP_W;

  logic [2:0][23:0] masks;

  logic                     s3_valid_r;
  logic signed [PROD_W-1:0] prod_r   [3][3];
  logic signed [PROD_W-1:0] prod_nxt [3][3];
  res_meta_t                s3_meta_r;

  logic                    s4_valid_r;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  res_meta_t               s4_meta_r;

  logic      out_valid_r;
  pixel_t    out_pix_r, pix_nxt;
  res_meta_t out_meta_r;

  logic          out_rdy, s4_rdy, s3_rdy;
  logic          neg, big;
  logic [QW-1:0] qprod;

  assign masks = {mask.bot, mask.mid, mask.top};

  assign out_rdy   = !out_valid_r || out_ready;
  assign s4_rdy    = !s4_valid_r || out_rdy;
  assign s3_rdy    = !s3_valid_r || s4_rdy;
  assign win_ready = s3_rdy;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nxt[k][j] = PROD_W'(mask_coef(masks[k], 2'(j))) *
                         PROD_W'($signed({1'b0, window[k][j]}));
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        sum_nxt = sum_nxt + SUM_W'(prod_r[k][j]);
      end
    end
  end

  // Negative sums truncate to a quotient of zero or below, so they give 0.
  always_comb begin
    neg     = sum_r[SUM_W-1];
    big     = !neg && (sum_r >= $signed(SUM_W'(DIV_CLAMP)));
    qprod   = QW'(sum_r[DIV_IN_W-1:0]) * QW'(DIV_RECIP);
    if (neg) begin
      pix_nxt = '0;
    end else if (big) begin
      pix_nxt = '1;
    end else begin
      pix_nxt = qprod[DIV_SHIFT +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s3_rdy) s3_valid_r <= win_valid;
      if (s4_rdy) s4_valid_r <= s3_valid_r;
      if (out_rdy) out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && win_valid) begin
      prod_r    <= prod_nxt;
      s3_meta_r <= meta;
    end
    if (s4_rdy && s3_valid_r) begin
      sum_r     <= sum_nxt;
      s4_meta_r <= s3_meta_r;
    end
    if (out_rdy && s4_valid_r) begin
      out_pix_r  <= pix_nxt;
      out_meta_r <= s4_meta_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_pixel  = out_pix_r;
  assign out_row    = out_meta_r.row;
  assign out_col    = out_meta_r.col;
  assign frame_last = out_meta_r.last;

endmodule

// ----- rtl/conv3x3_div9_clamp_top.sv -----
// ----------------------------------------------------------------------------
// conv3x3_div9_clamp_top: 3x3 convolution filter, divide by nine, clamp
//
//   Channel   Dir  Payload                                  Beat
//   in_ch     in   pixel, frame_start                       one pixel, raster order
//   out_ch    out  out_pixel, out_row, out_col, frame_last  one interior result
//   cfg_*     in   cfg_idx, cfg_wdata                       cfg_we high
//
// One pixel is accepted every clock while the pipeline is not full; the line
// stores take one read and one write per pixel, which sets that rate.
// A result moves through the read, window, product, sum and output registers.
// Border pixels pass through the line stores and give no result.
// A stall on out_ch fills the pipeline stages behind it before in_ch stalls.
// Synchronous active-low reset clears the position and all valid flags.
// ----------------------------------------------------------------------------
module conv3x3_div9_clamp_top
  import cv9_pkg::*;
#(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  cv9_in_if.sink                in_ch,
  cv9_out_if.source             out_ch
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);

  mask_t       mask;
  logic [RW:0] rows;
  logic [CW:0] cols;

  logic      win_valid, win_ready;
  window_t   window;
  res_meta_t meta;

  cv9_cfg #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .mask      (mask),
    .rows      (rows),
    .cols      (cols)
  );

  cv9_window #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_window (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_pixel       (in_ch.pixel),
    .in_frame_start (in_ch.frame_start),
    .rows           (rows),
    .cols           (cols),
    .win_valid      (win_valid),
    .win_ready      (win_ready),
    .window         (window),
    .meta           (meta)
  );

  cv9_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .mask       (mask),
    .win_valid  (win_valid),
    .win_ready  (win_ready),
    .window     (window),
    .meta       (meta),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_pixel  (out_ch.out_pixel),
    .out_row    (out_ch.out_row),
    .out_col    (out_ch.out_col),
    .frame_last (out_ch.frame_last)
  );

endmodule

// ----- rtl/cv9_checker.sv -----
// ----------------------------------------------------------------------------
// cv9_checker: port-level checks of the filter
// Watches the top-level ports; attached to the top level by bind.
// ----------------------------------------------------------------------------
module cv9_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_pixel,
  input logic [9:0] out_row,
  input logic [9:0] out_col,
  input logic       frame_last
);

  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_pixel, out_row, out_col, frame_last}))
    else $error("result payload changed while stalled");

  // Reset leaves no result pending and the input open.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not cleared by reset");

  // The input only stalls when the whole pipeline is full behind a stalled output.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without an output stall");

  // Results are always interior pixels.
  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_row != 10'd0 && out_col != 10'd0)
    else $error("result on a border pixel");

endmodule

bind conv3x3_div9_clamp_top cv9_checker u_cv9_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_pixel  (out_ch.out_pixel),
  .out_row    (out_ch.out_row),
  .out_col    (out_ch.out_col),
  .frame_last (out_ch.frame_last)
);
